[rtl/brmp_pkg.sv]
// Shared types and constants for the configurable bit remap unit.
// No dependencies; used by every module in rtl/.
`timescale 1ns / 1ps
`default_nettype none

package brmp_pkg;

   // Field widths of the request and response payloads
   localparam int DATA_W      = 32;
   localparam int POS_W       = 5;
   localparam int SRC_W       = 5;
   localparam int KIND_W      = 2;
   localparam int ACT_W       = 2;
   localparam int CFG_W       = 6;
   localparam int CSR_INDEX_W = 2;

   // Request actions
   localparam logic [ACT_W-1:0] ACT_WRITE = 2'd0;
   localparam logic [ACT_W-1:0] ACT_TO    = 2'd1;
   localparam logic [ACT_W-1:0] ACT_FROM  = 2'd2;

   // Mapping entry kinds
   localparam logic [KIND_W-1:0] KIND_ZERO = 2'd0;
   localparam logic [KIND_W-1:0] KIND_ONE  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_COPY = 2'd2;

   // CSR register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_SOURCE_WIDTH    = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_CONVERTED_WIDTH = 2'd1;

   // CSR reset values
   localparam logic [CFG_W-1:0] SOURCE_WIDTH_RST    = 6'd32;
   localparam logic [CFG_W-1:0] CONVERTED_WIDTH_RST = 6'd0;

   typedef struct packed {
      logic [ACT_W-1:0]  action;
      logic [POS_W-1:0]  entry_position;
      logic [KIND_W-1:0] entry_kind;
      logic [SRC_W-1:0]  entry_source;
      logic [DATA_W-1:0] data_in;
   } req_type;

   typedef struct packed {
      logic [DATA_W-1:0] data_out;
      logic              rejected;
   } rsp_type;

   // One mapping table entry
   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [SRC_W-1:0]  src;
   } entry_type;

   // Table write command from the datapath to the table
   typedef struct packed {
      logic              en;
      logic [POS_W-1:0]  pos;
      entry_type         entry;
   } tbl_wr_type;

endpackage

`default_nettype wire

[rtl/brmp_table.sv]
// Mapping table: one register entry per converted bit position.
// Depends on brmp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module brmp_table #(
   parameter int DEPTH = 32
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire brmp_pkg::tbl_wr_type              wr,
   output      brmp_pkg::entry_type [DEPTH-1:0]   map_entries
);

   localparam int IDX_W = $clog2(DEPTH);

   brmp_pkg::entry_type [DEPTH-1:0] map_ff;
   brmp_pkg::entry_type [DEPTH-1:0] map_in;

   // Replace the addressed entry; writer guarantees pos < DEPTH
   always_comb begin
      map_in = map_ff;
      if (wr.en) begin
         map_in[wr.pos[IDX_W-1:0]] = wr.entry;
      end
   end

   // Reset makes every entry forced zero
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DEPTH; i++) begin
            map_ff[i] <= '{kind: brmp_pkg::KIND_ZERO, src: '0};
         end
      end else begin
         map_ff <= map_in;
      end
   end

   assign map_entries = map_ff;

endmodule

`default_nettype wire

[rtl/brmp_xbar.sv]
// Remap datapath: write checks, convert-to gather and convert-from scatter.
// Pure combinational; depends on brmp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module brmp_xbar #(
   parameter int DEPTH = 32
) (
   input  wire brmp_pkg::req_type                  item,
   input  wire brmp_pkg::entry_type [DEPTH-1:0]    map_entries,
   input  wire logic [brmp_pkg::CFG_W-1:0]         src_width,
   input  wire logic [brmp_pkg::CFG_W-1:0]         conv_width,
   output      brmp_pkg::rsp_type                  result,
   output      brmp_pkg::tbl_wr_type               wr
);

   localparam logic [brmp_pkg::CFG_W-1:0] MaxW = brmp_pkg::CFG_W'(DEPTH);

   logic [brmp_pkg::CFG_W-1:0]  sw_eff;
   logic [brmp_pkg::CFG_W-1:0]  cw_eff;
   logic [brmp_pkg::KIND_W-1:0] kind_norm;
   logic                        rej;
   logic [brmp_pkg::DATA_W-1:0] to_word;
   logic [brmp_pkg::DATA_W-1:0] from_word;
   logic [DEPTH-1:0]            lane_on;

   // Effective widths, clamped to the table size
   assign sw_eff = (src_width  > MaxW) ? MaxW : src_width;
   assign cw_eff = (conv_width > MaxW) ? MaxW : conv_width;

   // Unused kind stores as forced zero
   assign kind_norm = (item.entry_kind == brmp_pkg::KIND_ONE ||
                       item.entry_kind == brmp_pkg::KIND_COPY) ?
                      item.entry_kind : brmp_pkg::KIND_ZERO;

   assign rej = (item.action == brmp_pkg::ACT_WRITE) &&
                (kind_norm == brmp_pkg::KIND_COPY) &&
                ({1'b0, item.entry_source} >= sw_eff);

   // Table write: accepted writes to positions inside the table
   always_comb begin
      wr.en        = (item.action == brmp_pkg::ACT_WRITE) && !rej &&
                     ({1'b0, item.entry_position} < MaxW);
      wr.pos       = item.entry_position;
      wr.entry.kind = kind_norm;
      wr.entry.src  = (kind_norm == brmp_pkg::KIND_COPY) ? item.entry_source : '0;
   end

   // Lanes below the converted width
   always_comb begin
      for (int p = 0; p < DEPTH; p++) begin
         lane_on[p] = brmp_pkg::CFG_W'(p) < cw_eff;
      end
   end

   // Convert to: each converted bit gathers from its entry
   always_comb begin
      to_word = '0;
      for (int p = 0; p < DEPTH; p++) begin
         if (lane_on[p]) begin
            case (map_entries[p].kind)
               brmp_pkg::KIND_ONE:  to_word[p] = 1'b1;
               brmp_pkg::KIND_COPY: to_word[p] = item.data_in[map_entries[p].src];
               default:             to_word[p] = 1'b0;
            endcase
         end
      end
   end

   // Convert from: each source bit ORs the copy lanes that name it
   always_comb begin
      from_word = '0;
      for (int s = 0; s < brmp_pkg::DATA_W; s++) begin
         for (int p = 0; p < DEPTH; p++) begin
            if (lane_on[p] && item.data_in[p] &&
                map_entries[p].kind == brmp_pkg::KIND_COPY &&
                map_entries[p].src == brmp_pkg::SRC_W'(s)) begin
               from_word[s] = 1'b1;
            end
         end
      end
   end

   // Result select
   always_comb begin
      result.rejected = rej;
      case (item.action)
         brmp_pkg::ACT_TO:   result.data_out = to_word;
         brmp_pkg::ACT_FROM: result.data_out = from_word;
         default:            result.data_out = '0;
      endcase
   end

endmodule

`default_nettype wire

[rtl/configurable_bit_remap_unit.sv]
// Top level of the configurable bit remap unit: request register, CSRs,
// result register. Depends on brmp_pkg, brmp_table and brmp_xbar.
//
//   Port group   Dir   Handshake            Payload
//   req_*        in    req_valid/req_ready  brmp_pkg::req_type
//   rsp_*        out   rsp_valid/rsp_ready  brmp_pkg::rsp_type
//   csr_*        in    csr_we               csr_index, csr_wdata
//
// One request per cycle sustained while responses are taken; a request moves from
// the request register through the single remap pass to the result register.
// A table write takes effect for the request right behind it.
// Synchronous reset clears the table to forced zero and loads CSR defaults.
// A stalled result holds the request register; only then does req_ready drop.
`timescale 1ns / 1ps
`default_nettype none

module configurable_bit_remap_unit #(
   parameter int MAX_BITS = 32
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output      logic                                req_ready,
   input  wire brmp_pkg::req_type                   req_payload,
   output      logic                                rsp_valid,
   input  wire logic                                rsp_ready,
   output      brmp_pkg::rsp_type                   rsp_payload,
   input  wire logic                                csr_we,
   input  wire logic [brmp_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire logic [brmp_pkg::CFG_W-1:0]          csr_wdata
);

   // Entry positions are 5 bits, so at most 32 entries are reachable
   localparam int TABLE_DEPTH = (MAX_BITS < 32) ? MAX_BITS : 32;

   logic                           s1_valid_ff, s1_valid_in;
   brmp_pkg::req_type              s1_req_ff;
   logic                           rsp_valid_ff, rsp_valid_in;
   brmp_pkg::rsp_type              rsp_ff;
   logic [brmp_pkg::CFG_W-1:0]     src_width_ff, src_width_in;
   logic [brmp_pkg::CFG_W-1:0]     conv_width_ff, conv_width_in;
   logic                           out_free;
   logic                           advance;
   logic                           req_accept;
   brmp_pkg::entry_type [TABLE_DEPTH-1:0] map_entries;
   brmp_pkg::rsp_type              pass_rsp;
   brmp_pkg::tbl_wr_type           pass_wr;
   brmp_pkg::tbl_wr_type           tbl_wr;

   // Flow control
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign advance    = s1_valid_ff && out_free;
   assign req_ready  = !s1_valid_ff || out_free;
   assign req_accept = req_valid && req_ready;

   assign s1_valid_in  = req_accept ? 1'b1 : (advance ? 1'b0 : s1_valid_ff);
   assign rsp_valid_in = advance ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   // CSR writes
   always_comb begin
      src_width_in  = src_width_ff;
      conv_width_in = conv_width_ff;
      if (csr_we) begin
         unique case (csr_index)
            brmp_pkg::CSR_SOURCE_WIDTH:    src_width_in  = csr_wdata;
            brmp_pkg::CSR_CONVERTED_WIDTH: conv_width_in = csr_wdata;
            default: ;
         endcase
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         src_width_ff  <= brmp_pkg::SOURCE_WIDTH_RST;
         conv_width_ff <= brmp_pkg::CONVERTED_WIDTH_RST;
      end else begin
         s1_valid_ff   <= s1_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         src_width_ff  <= src_width_in;
         conv_width_ff <= conv_width_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_req_ff <= req_payload;
      end
      if (advance) begin
         rsp_ff <= pass_rsp;
      end
   end

   brmp_xbar #(
      .DEPTH(TABLE_DEPTH)
   ) u_xbar (
      .item        (s1_req_ff),
      .map_entries (map_entries),
      .src_width   (src_width_ff),
      .conv_width  (conv_width_ff),
      .result      (pass_rsp),
      .wr          (pass_wr)
   );

   // Commit a table write only when its request moves to the result register
   always_comb begin
      tbl_wr    = pass_wr;
      tbl_wr.en = pass_wr.en && advance;
   end

   brmp_table #(
      .DEPTH(TABLE_DEPTH)
   ) u_table (
      .clock       (clock),
      .reset       (reset),
      .wr          (tbl_wr),
      .map_entries (map_entries)
   );

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // Checks
   a_accept_loads: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> s1_valid_ff)
      else $error("accepted request not held in request register");

   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !out_free) |-> !req_ready)
      else $error("request accepted while request register is blocked");

   a_reject_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.rejected) |-> (rsp_ff.data_out == '0))
      else $error("rejected write carries nonzero data");

   a_write_commit: assert property (@(posedge clock) disable iff (reset)
      tbl_wr.en |-> (s1_req_ff.action == brmp_pkg::ACT_WRITE && !pass_rsp.rejected))
      else $error("table written by a non-write or rejected request");

endmodule

`default_nettype wire

[tb/sv/brmp_remap_checker.sv]
// Response checker for the configurable bit remap unit: tracks the CSRs and
// the mapping table, predicts every accepted request and compares responses.
// Depends on brmp_pkg.
`timescale 1ns / 1ps

module brmp_remap_checker #(
   parameter int MAX_BITS = 32
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   input  wire logic                             req_ready,
   input  wire brmp_pkg::req_type                req_payload,
   input  wire logic                             rsp_valid,
   input  wire logic                             rsp_ready,
   input  wire brmp_pkg::rsp_type                rsp_payload,
   input  wire logic                             csr_we,
   input  wire logic [brmp_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [brmp_pkg::CFG_W-1:0]       csr_wdata,
   output int                                    fail_count,
   output int                                    pending_count
);

   import brmp_pkg::*;

   // effective widths never exceed the table or the data word
   localparam int WIDTH_CAP = (MAX_BITS < DATA_W) ? MAX_BITS : DATA_W;

   entry_type        wiring [MAX_BITS];
   logic [CFG_W-1:0] src_width_q;
   logic [CFG_W-1:0] conv_width_q;
   rsp_type          expected_remaps [$];
   int               fails = 0;

   function automatic int clamp_width(logic [CFG_W-1:0] w);
      return (int'(w) < WIDTH_CAP) ? int'(w) : WIDTH_CAP;
   endfunction

   // Expected response of one request; table writes update the local copy
   function automatic rsp_type compute_remap(req_type r);
      rsp_type           res;
      logic [KIND_W-1:0] k;
      int                sw;
      int                cw;
      int                p;
      res = '0;
      sw  = clamp_width(src_width_q);
      cw  = clamp_width(conv_width_q);
      case (r.action)
         ACT_WRITE: begin
            // unused kind code is stored as forced zero
            k = (r.entry_kind == KIND_ONE || r.entry_kind == KIND_COPY) ?
                r.entry_kind : KIND_ZERO;
            if (k == KIND_COPY && int'(r.entry_source) >= sw) begin
               res.rejected = 1'b1;
            end else if (int'(r.entry_position) < MAX_BITS) begin
               wiring[r.entry_position].kind = k;
               wiring[r.entry_position].src  = (k == KIND_COPY) ? r.entry_source : '0;
            end
         end
         ACT_TO: begin
            for (p = 0; p < cw; p++) begin
               case (wiring[p].kind)
                  KIND_ONE:  res.data_out[p] = 1'b1;
                  KIND_COPY: res.data_out[p] = r.data_in[wiring[p].src];
                  default:   res.data_out[p] = 1'b0;
               endcase
            end
         end
         ACT_FROM: begin
            // scatter copied bits back; forced bits give nothing
            for (p = 0; p < cw; p++) begin
               if (wiring[p].kind == KIND_COPY && r.data_in[p])
                  res.data_out[wiring[p].src] = 1'b1;
            end
         end
         default: ;
      endcase
      return res;
   endfunction

   // Compare responses, then queue predictions for new requests
   always @(posedge clock) begin
      rsp_type want;
      rsp_type pred;
      int      i;
      if (reset) begin
         for (i = 0; i < MAX_BITS; i++) wiring[i] = '0;
         src_width_q  = SOURCE_WIDTH_RST;
         conv_width_q = CONVERTED_WIDTH_RST;
         expected_remaps.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_remaps.size() == 0) begin
               $display("%0t: unexpected response: expected none, got data_out=%h rejected=%b",
                        $time, rsp_payload.data_out, rsp_payload.rejected);
               fails++;
            end else begin
               want = expected_remaps.pop_front();
               if (rsp_payload.data_out !== want.data_out) begin
                  $display("%0t: data_out mismatch: expected %h, got %h",
                           $time, want.data_out, rsp_payload.data_out);
                  fails++;
               end
               if (rsp_payload.rejected !== want.rejected) begin
                  $display("%0t: rejected mismatch: expected %b, got %b",
                           $time, want.rejected, rsp_payload.rejected);
                  fails++;
               end
            end
         end
         if (req_valid && req_ready) begin
            pred = compute_remap(req_payload);
            expected_remaps.insert(expected_remaps.size(), pred);
         end
         if (csr_we) begin
            case (csr_index)
               CSR_SOURCE_WIDTH:    src_width_q  = csr_wdata;
               CSR_CONVERTED_WIDTH: conv_width_q = csr_wdata;
               default: ;
            endcase
         end
      end
      fail_count    <= fails;
      pending_count <= expected_remaps.size();
   end

endmodule

[tb/sv/testbench.sv]
// Top of the bit remap unit testbench: clock, reset, request and CSR stimulus,
// response backpressure, watchdog and verdict.
// Depends on brmp_pkg, configurable_bit_remap_unit and brmp_remap_checker.
`timescale 1ns / 1ps

module testbench;

   import brmp_pkg::*;

   localparam int MAX_BITS     = 32;
   localparam int CLK_HALF     = 10;
   localparam int RESET_CYCLES = 10;
   localparam int STALL_LIMIT  = 4000;
   localparam int PHASES       = 10;
   localparam int PHASE_ITEMS  = 95;
   localparam int HOLD_PHASE   = 3;
   localparam int HOLD_CYCLES  = 300;
   localparam int DRAIN_CYCLES = 8;

   // codes the block leaves unused
   localparam logic [ACT_W-1:0]  ACT_NONE  = 2'd3;
   localparam logic [KIND_W-1:0] KIND_NONE = 2'd3;

   logic                   clock       = 1'b0;
   logic                   reset       = 1'b1;
   logic                   req_valid   = 1'b0;
   logic                   req_ready;
   req_type                req_payload = '0;
   logic                   rsp_valid;
   logic                   rsp_ready   = 1'b0;
   rsp_type                rsp_payload;
   logic                   csr_we      = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index   = '0;
   logic [CFG_W-1:0]       csr_wdata   = '0;
   int                     fail_count;
   int                     pending_count;

   // idling controls shared with the response side
   bit tx_steady    = 1'b1;
   bit rsp_steady   = 1'b1;
   bit hold_request = 1'b0;

   always begin
      #CLK_HALF clock = 1'b1;
      #CLK_HALF clock = 1'b0;
   end

   configurable_bit_remap_unit #(
      .MAX_BITS(MAX_BITS)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_payload(req_payload),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_payload(rsp_payload),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   brmp_remap_checker #(
      .MAX_BITS(MAX_BITS)
   ) u_checker (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_payload  (req_payload),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_payload  (rsp_payload),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .fail_count   (fail_count),
      .pending_count(pending_count)
   );

   function automatic req_type make_req(logic [ACT_W-1:0] act, logic [POS_W-1:0] pos,
                                        logic [KIND_W-1:0] kind, logic [SRC_W-1:0] src,
                                        logic [DATA_W-1:0] data);
      return '{action: act, entry_position: pos, entry_kind: kind,
               entry_source: src, data_in: data};
   endfunction

   // Mostly well-formed writes and conversions, some noise
   function automatic req_type random_item(int sw);
      req_type r;
      int      eff;
      int      roll;
      eff              = (sw < DATA_W) ? sw : DATA_W;
      roll             = $urandom_range(0, 99);
      r.entry_position = POS_W'($urandom);
      r.entry_source   = SRC_W'($urandom);
      r.data_in        = $urandom;
      case ($urandom_range(0, 3))
         0:       r.entry_kind = KIND_ZERO;
         1:       r.entry_kind = KIND_ONE;
         default: r.entry_kind = KIND_COPY;
      endcase
      if (roll < 35) begin
         r.action = ACT_WRITE;
         if (eff > 0 && $urandom_range(0, 9) != 0)
            r.entry_source = SRC_W'($urandom_range(0, eff - 1));
      end else if (roll < 62) begin
         r.action = ACT_TO;
      end else if (roll < 89) begin
         r.action = ACT_FROM;
      end else begin
         r.action     = ACT_W'($urandom);
         r.entry_kind = KIND_W'($urandom);
      end
      case ($urandom_range(0, 15))
         0:       r.data_in = '0;
         1:       r.data_in = '1;
         default: ;
      endcase
      return r;
   endfunction

   // Offer one request after a random gap and wait until it is taken
   task automatic send_request(input req_type r);
      int gap;
      int roll;
      gap  = 0;
      roll = $urandom_range(0, 19);
      if (!tx_steady) begin
         if (roll == 0)
            gap = $urandom_range(10, 40);
         else if (roll > 11)
            gap = $urandom_range(1, 3);
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // Drain the block, then load both width registers
   task automatic set_widths(input logic [CFG_W-1:0] sw, input logic [CFG_W-1:0] cw);
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= CSR_SOURCE_WIDTH;
      csr_wdata <= sw;
      @(posedge clock);
      csr_index <= CSR_CONVERTED_WIDTH;
      csr_wdata <= cw;
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   // Response side: random stalls, steady stretches, one long hold-off
   initial begin : receiver
      int len;
      forever begin
         if (hold_request) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_request = 1'b0;
         end else if (rsp_steady || $urandom_range(0, 3) != 0) begin
            rsp_ready <= 1'b1;
            @(posedge clock);
         end else begin
            len = ($urandom_range(0, 19) == 0) ? $urandom_range(15, 60) : $urandom_range(1, 3);
            rsp_ready <= 1'b0;
            repeat (len) @(posedge clock);
         end
      end
   end

   // Ends the run when neither channel moves for too long
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("%0t: no request or response accepted for %0d cycles", $time, STALL_LIMIT);
      $display("Simulation FAILED");
      $finish;
   end

   initial begin : stimulus
      int sw;
      int cw;
      int phase;
      int n;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // reset widths: nothing converts, unused action is a no-op
      send_request(make_req(ACT_TO, '0, KIND_ZERO, '0, '1));
      send_request(make_req(ACT_FROM, '0, KIND_ZERO, '0, '1));
      send_request(make_req(ACT_NONE, '1, KIND_COPY, '1, '1));

      // full widths: forced bits, copies at both ends, unused kind
      set_widths(6'd32, 6'd32);
      send_request(make_req(ACT_WRITE, 5'd0, KIND_ONE, 5'd0, '0));
      send_request(make_req(ACT_WRITE, 5'd31, KIND_COPY, 5'd31, '1));
      send_request(make_req(ACT_WRITE, 5'd1, KIND_COPY, 5'd0, '0));
      send_request(make_req(ACT_WRITE, 5'd2, KIND_NONE, 5'd17, '0));
      send_request(make_req(ACT_WRITE, 5'd3, KIND_ZERO, 5'd31, '0));
      send_request(make_req(ACT_WRITE, 5'd4, KIND_ONE, 5'd31, '0));
      send_request(make_req(ACT_TO, '0, KIND_ZERO, '0, '1));
      send_request(make_req(ACT_TO, '0, KIND_ZERO, '0, '0));
      send_request(make_req(ACT_FROM, '0, KIND_ZERO, '0, '1));
      send_request(make_req(ACT_FROM, '0, KIND_ZERO, '0, '0));
      send_request(make_req(ACT_NONE, 5'd5, KIND_ONE, '0, 32'hA5A5_5A5A));

      // narrow source: out-of-range copy rejected, old entries still copy
      set_widths(6'd1, 6'd32);
      send_request(make_req(ACT_WRITE, 5'd5, KIND_COPY, 5'd1, '0));
      send_request(make_req(ACT_WRITE, 5'd6, KIND_COPY, 5'd0, '0));
      send_request(make_req(ACT_TO, '0, KIND_ZERO, '0, '1));
      send_request(make_req(ACT_FROM, '0, KIND_ZERO, '0, '1));

      // zero source width, converted bit 31 beyond the width
      set_widths(6'd0, 6'd31);
      send_request(make_req(ACT_WRITE, 5'd7, KIND_COPY, 5'd0, '0));
      send_request(make_req(ACT_TO, '0, KIND_ZERO, '0, '1));
      send_request(make_req(ACT_FROM, '0, KIND_ZERO, '0, '1));

      // register values above the word width
      set_widths(6'd63, 6'd63);
      send_request(make_req(ACT_TO, '0, KIND_ZERO, '0, 32'h8000_0001));
      send_request(make_req(ACT_FROM, '0, KIND_ZERO, '0, 32'h8000_0003));

      // random phases, each with its own widths and idling
      for (phase = 0; phase < PHASES; phase++) begin
         case (phase == 0 ? 1 : $urandom_range(0, 5))
            0:       sw = 0;
            1:       sw = 32;
            2:       sw = 63;
            3:       sw = 1;
            default: sw = $urandom_range(1, 32);
         endcase
         case (phase == 0 ? 1 : $urandom_range(0, 5))
            0:       cw = 0;
            1:       cw = 32;
            2:       cw = 63;
            default: cw = $urandom_range(1, 32);
         endcase
         set_widths(CFG_W'(sw), CFG_W'(cw));
         tx_steady  = ($urandom_range(0, 3) == 0);
         rsp_steady = ($urandom_range(0, 3) == 0);
         if (phase == HOLD_PHASE) begin
            tx_steady    = 1'b1;
            hold_request = 1'b1;
         end
         for (n = 0; n < PHASE_ITEMS; n++)
            send_request(random_item(sw));
      end

      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && pending_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
